FILE: design/touch_gesture_recognizer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the touch gesture recognizer
// Shared concurrent assertion forms; the using module provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TGR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tgr_pkg.sv
// ---------------------------------------------------------------------------
// Touch gesture recognizer package
// Types, register indexes, reset values and codes shared by the front, back and top modules.
// ---------------------------------------------------------------------------
package tgr_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_SENSE_MODE         = 3'd0;
    localparam logic [2:0] CFG_TOUCH_THRESHOLD    = 3'd1;
    localparam logic [2:0] CFG_SETTLE_MS          = 3'd2;
    localparam logic [2:0] CFG_TAP_LIMIT_MS       = 3'd3;
    localparam logic [2:0] CFG_HOLD_START_MS      = 3'd4;
    localparam logic [2:0] CFG_SECOND_TAP_WAIT_MS = 3'd5;
    localparam logic [2:0] CFG_POLL_INTERVAL_MS   = 3'd6;

    // Register reset values
    localparam logic        RST_SENSE_MODE         = 1'b0;
    localparam logic [15:0] RST_TOUCH_THRESHOLD    = 16'd40;
    localparam logic [15:0] RST_SETTLE_MS          = 16'd50;
    localparam logic [15:0] RST_TAP_LIMIT_MS       = 16'd250;
    localparam logic [15:0] RST_HOLD_START_MS      = 16'd800;
    localparam logic [15:0] RST_SECOND_TAP_WAIT_MS = 16'd300;
    localparam logic [15:0] RST_POLL_INTERVAL_MS   = 16'd20;

    // Gesture state machine
    typedef enum logic [2:0] {
        ST_IDLE            = 3'd0,
        ST_TOUCHING        = 3'd1,
        ST_WAIT_DOUBLE     = 3'd2,
        ST_SECOND_TOUCHING = 3'd3,
        ST_LONG_ACTIVE     = 3'd4
    } gesture_state_t;

    // Event codes
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_SINGLE     = 3'd1,
        EV_DOUBLE     = 3'd2,
        EV_LONG_START = 3'd3,
        EV_LONG_END   = 3'd4
    } gesture_event_t;

    // Configuration registers as seen by the front and back
    typedef struct packed {
        logic        sense_mode;
        logic [15:0] touch_threshold;
        logic [15:0] settle_ms;
        logic [15:0] tap_limit_ms;
        logic [15:0] hold_start_ms;
        logic [15:0] second_tap_wait_ms;
        logic [15:0] poll_interval_ms;
    } cfg_t;

    // Word from front to back: classified sample
    typedef struct packed {
        logic        processed;
        logic        stable_touch;
        logic [31:0] time_ms;
        logic [15:0] raw_latch;
    } mid_word_t;

    // Result word
    typedef struct packed {
        gesture_event_t gesture_event;
        logic [31:0]    event_time_ms;
        logic [15:0]    last_raw_value;
    } res_word_t;

endpackage

FILE: design/tgr_fifo.sv
// ---------------------------------------------------------------------------
// Small register FIFO
// Generic first-in first-out queue with count-based full and empty.
// ---------------------------------------------------------------------------
`include "touch_gesture_recognizer_assert.svh"

module tgr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `TGR_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(DEPTH),
        "fifo count beyond depth")
    `TGR_ASSERT_NEXT(a_push_grows, push_ok && !pop_ok, count_reg == $past(count_reg) + 1'b1,
        "fifo count did not grow on push")

endmodule

FILE: design/tgr_front.sv
// ---------------------------------------------------------------------------
// Gesture recognizer front end
// Throttles samples, picks the touch level and debounces it.
// ---------------------------------------------------------------------------
module tgr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [31:0]       time_ms,
    input  logic              pin_level,
    input  logic [15:0]       raw_reading,
    input  tgr_pkg::cfg_t     cfg,
    output tgr_pkg::mid_word_t word
);

    logic [31:0] last_sample_time_reg, last_sample_time_next;
    logic        raw_touch_prev_reg, raw_touch_prev_next;
    logic [31:0] raw_change_time_reg, raw_change_time_next;
    logic        stable_touch_reg, stable_touch_next;
    logic [15:0] raw_value_latch_reg, raw_value_latch_next;

    logic [31:0] since_sample;
    logic [31:0] since_change;
    logic        processed;
    logic        touch;

    // Throttle and debounce
    always_comb
    begin
        last_sample_time_next = last_sample_time_reg;
        raw_touch_prev_next   = raw_touch_prev_reg;
        raw_change_time_next  = raw_change_time_reg;
        stable_touch_next     = stable_touch_reg;
        raw_value_latch_next  = raw_value_latch_reg;

        since_sample = time_ms - last_sample_time_reg;
        since_change = time_ms - raw_change_time_reg;
        processed    = (since_sample >= {16'd0, cfg.poll_interval_ms});
        touch        = cfg.sense_mode ? (raw_reading < cfg.touch_threshold) : pin_level;

        if (accept && processed)
        begin
            last_sample_time_next = time_ms;
            if (cfg.sense_mode)
            begin
                raw_value_latch_next = raw_reading;
            end
            if (touch != raw_touch_prev_reg)
            begin
                // fresh edge: zero elapsed time never exceeds the window
                raw_touch_prev_next  = touch;
                raw_change_time_next = time_ms;
            end
            else if (since_change > {16'd0, cfg.settle_ms})
            begin
                stable_touch_next = raw_touch_prev_reg;
            end
        end

        word.processed    = processed;
        word.stable_touch = stable_touch_next;
        word.time_ms      = time_ms;
        word.raw_latch    = raw_value_latch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_time_reg <= '0;
            raw_touch_prev_reg   <= 1'b0;
            raw_change_time_reg  <= '0;
            stable_touch_reg     <= 1'b0;
            raw_value_latch_reg  <= '0;
        end
        else
        begin
            last_sample_time_reg <= last_sample_time_next;
            raw_touch_prev_reg   <= raw_touch_prev_next;
            raw_change_time_reg  <= raw_change_time_next;
            stable_touch_reg     <= stable_touch_next;
            raw_value_latch_reg  <= raw_value_latch_next;
        end
    end

endmodule

FILE: design/tgr_back.sv
// ---------------------------------------------------------------------------
// Gesture recognizer back end
// Runs the gesture state machine on debounced words and builds results.
// ---------------------------------------------------------------------------
`include "touch_gesture_recognizer_assert.svh"

module tgr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    input  tgr_pkg::mid_word_t word,
    input  logic               res_full,
    input  tgr_pkg::cfg_t      cfg,
    output logic               take,
    output tgr_pkg::res_word_t res
);

    tgr_pkg::gesture_state_t state_reg, state_next;
    logic [31:0]             press_start_time_reg, press_start_time_next;
    logic [31:0]             first_release_time_reg, first_release_time_next;
    tgr_pkg::gesture_event_t ev;
    logic [31:0]             held;
    logic [31:0]             since_release;

    assign take = word_valid && !res_full;

    // Next state and result
    always_comb
    begin
        state_next              = state_reg;
        press_start_time_next   = press_start_time_reg;
        first_release_time_next = first_release_time_reg;
        ev                      = tgr_pkg::EV_NONE;
        held                    = word.time_ms - press_start_time_reg;
        since_release           = word.time_ms - first_release_time_reg;

        if (take && word.processed)
        begin
            unique case (state_reg)
                tgr_pkg::ST_TOUCHING:
                begin
                    if (!word.stable_touch)
                    begin
                        if (held <= {16'd0, cfg.tap_limit_ms})
                        begin
                            state_next              = tgr_pkg::ST_WAIT_DOUBLE;
                            first_release_time_next = word.time_ms;
                        end
                        else
                        begin
                            state_next = tgr_pkg::ST_IDLE;
                        end
                    end
                    else if (held >= {16'd0, cfg.hold_start_ms})
                    begin
                        state_next = tgr_pkg::ST_LONG_ACTIVE;
                        ev         = tgr_pkg::EV_LONG_START;
                    end
                end
                tgr_pkg::ST_WAIT_DOUBLE:
                begin
                    if (word.stable_touch)
                    begin
                        state_next = tgr_pkg::ST_SECOND_TOUCHING;
                    end
                    else if (since_release > {16'd0, cfg.second_tap_wait_ms})
                    begin
                        state_next = tgr_pkg::ST_IDLE;
                        ev         = tgr_pkg::EV_SINGLE;
                    end
                end
                tgr_pkg::ST_SECOND_TOUCHING:
                begin
                    if (!word.stable_touch)
                    begin
                        state_next = tgr_pkg::ST_IDLE;
                        ev         = tgr_pkg::EV_DOUBLE;
                    end
                end
                tgr_pkg::ST_LONG_ACTIVE:
                begin
                    if (!word.stable_touch)
                    begin
                        state_next = tgr_pkg::ST_IDLE;
                        ev         = tgr_pkg::EV_LONG_END;
                    end
                end
                default:
                begin
                    // idle, and any stray code
                    if (word.stable_touch)
                    begin
                        state_next            = tgr_pkg::ST_TOUCHING;
                        press_start_time_next = word.time_ms;
                    end
                    else
                    begin
                        state_next = tgr_pkg::ST_IDLE;
                    end
                end
            endcase
        end

        res.gesture_event  = ev;
        res.event_time_ms  = (ev != tgr_pkg::EV_NONE) ? word.time_ms : 32'd0;
        res.last_raw_value = word.raw_latch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= tgr_pkg::ST_IDLE;
            press_start_time_reg   <= '0;
            first_release_time_reg <= '0;
        end
        else
        begin
            state_reg              <= state_next;
            press_start_time_reg   <= press_start_time_next;
            first_release_time_reg <= first_release_time_next;
        end
    end

    `TGR_ASSERT_IMPL(a_event_from_sample, ev != tgr_pkg::EV_NONE, take && word.processed,
        "event raised without a processed word")
    `TGR_ASSERT_NEXT(a_long_start_state, ev == tgr_pkg::EV_LONG_START,
        state_reg == tgr_pkg::ST_LONG_ACTIVE, "long press start did not enter long state")

endmodule

FILE: design/touch_gesture_recognizer.sv
// ---------------------------------------------------------------------------
// Touch gesture recognizer
// Throttled, debounced touch sampling with tap, double tap and long press.
// ---------------------------------------------------------------------------
//   channel   handshake              payload
//   sample    push / full            time_ms, pin_level, raw_reading
//   result    pop / empty            gesture_event, event_time_ms, last_raw_value
//   config    cfg_we                 cfg_index, cfg_data
//
// One sample per cycle in while the word queue is not full, one result per
// sample out; a result reaches the result ports through one register stage
// in the front-to-back word queue and one in the result queue.
// The front stalls only when the word queue is full; the back stalls only
// when the result queue is full. Reset clears all state but the queue
// storage and loads the register defaults at once.
// ---------------------------------------------------------------------------
module touch_gesture_recognizer #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] time_ms,
    input  logic        pin_level,
    input  logic [15:0] raw_reading,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  gesture_event,
    output logic [31:0] event_time_ms,
    output logic [15:0] last_raw_value,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tgr_pkg::cfg_t      cfg_reg, cfg_next;
    tgr_pkg::mid_word_t front_word, back_word;
    tgr_pkg::res_word_t back_res, out_res;
    logic               accept;
    logic               mid_empty;
    logic               take;
    logic               res_full;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tgr_pkg::CFG_SENSE_MODE:         cfg_next.sense_mode         = cfg_data[0];
                tgr_pkg::CFG_TOUCH_THRESHOLD:    cfg_next.touch_threshold    = cfg_data;
                tgr_pkg::CFG_SETTLE_MS:          cfg_next.settle_ms          = cfg_data;
                tgr_pkg::CFG_TAP_LIMIT_MS:       cfg_next.tap_limit_ms       = cfg_data;
                tgr_pkg::CFG_HOLD_START_MS:      cfg_next.hold_start_ms      = cfg_data;
                tgr_pkg::CFG_SECOND_TAP_WAIT_MS: cfg_next.second_tap_wait_ms = cfg_data;
                tgr_pkg::CFG_POLL_INTERVAL_MS:   cfg_next.poll_interval_ms   = cfg_data;
                default:                         cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sense_mode         <= tgr_pkg::RST_SENSE_MODE;
            cfg_reg.touch_threshold    <= tgr_pkg::RST_TOUCH_THRESHOLD;
            cfg_reg.settle_ms          <= tgr_pkg::RST_SETTLE_MS;
            cfg_reg.tap_limit_ms       <= tgr_pkg::RST_TAP_LIMIT_MS;
            cfg_reg.hold_start_ms      <= tgr_pkg::RST_HOLD_START_MS;
            cfg_reg.second_tap_wait_ms <= tgr_pkg::RST_SECOND_TAP_WAIT_MS;
            cfg_reg.poll_interval_ms   <= tgr_pkg::RST_POLL_INTERVAL_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = push && !full;

    // Front: throttle and debounce
    tgr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .time_ms     (time_ms),
        .pin_level   (pin_level),
        .raw_reading (raw_reading),
        .cfg         (cfg_reg),
        .word        (front_word)
    );

    // Word queue between front and back
    tgr_fifo #(
        .WIDTH ($bits(tgr_pkg::mid_word_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_word),
        .full    (full),
        .pop     (take),
        .rd_data (back_word),
        .empty   (mid_empty)
    );

    // Back: gesture state machine
    tgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (!mid_empty),
        .word       (back_word),
        .res_full   (res_full),
        .cfg        (cfg_reg),
        .take       (take),
        .res        (back_res)
    );

    // Result queue
    tgr_fifo #(
        .WIDTH ($bits(tgr_pkg::res_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign gesture_event  = out_res.gesture_event;
    assign event_time_ms  = out_res.event_time_ms;
    assign last_raw_value = out_res.last_raw_value;

endmodule
